FILE: rtl/ppip_pkg.sv
// Shared types and constants of the point to pixel index projector.
package ppip_pkg;

   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 512;
   localparam int PROJ_REGS    = 6;
   localparam int Q16_FRAC     = 16;

   localparam logic [10:0] COLS_RESET = 11'd640;
   localparam logic [9:0]  ROWS_RESET = 10'd480;

   typedef enum logic [2:0] {
      REG_ROW0_COLS01 = 3'd0,
      REG_ROW0_COLS23 = 3'd1,
      REG_ROW1_COLS01 = 3'd2,
      REG_ROW1_COLS23 = 3'd3,
      REG_ROW2_COLS01 = 3'd4,
      REG_ROW2_COLS23 = 3'd5,
      REG_IMAGE_COLS  = 3'd6,
      REG_IMAGE_ROWS  = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_PROJECT    = 1'b0,
      CMD_MASK_WRITE = 1'b1
   } command_type;

   typedef struct packed {
      logic               command;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [18:0]        mask_address;
      logic               mask_bit;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [18:0] pixel_index;
   } rsp_type;

   // Item bookkeeping that rides along the pipeline.
   typedef struct packed {
      logic        is_write;
      logic [18:0] mask_address;
      logic        mask_bit;
   } meta_type;

endpackage

FILE: rtl/ppip_if.sv
// Handshake channel interfaces: point/mask requests, results, register writes.
interface ppip_req_if;
   logic              valid;
   logic              ready;
   ppip_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ppip_rsp_if;
   logic              valid;
   logic              ready;
   ppip_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ppip_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/point_to_pixel_index_projector.sv
// Top level of the point to pixel index projector.
// Requests arrive on req_ch: a projection (command 0) carries a Q16.16 point,
// a mask write (command 1) carries a pixel address and mask bit. Each
// projection yields exactly one transfer on rsp_ch (hit flag and row-flipped
// pixel index); mask writes yield none. Matrix and image size are written on
// csr_ch (always ready); the user must write them only while no item is in
// flight, which the block itself does not enforce. The pipeline has three
// multiply-add stages, one divider set-up stage, one restoring-divider stage
// per quotient bit (QW = clog2(max(MAX_COLS, MAX_ROWS) + 1) bits), bounds,
// index and mask read. Throughput is one item per cycle while rsp_ch does not
// stall and the mask fill is over; mask writes and projections mix freely and
// keep their order at the mask memory. Reset clears the valid flags and the
// matrix, sets the image size to 640 x 480 and starts a fill of the mask
// memory with ones, during which req_ch is not ready. When rsp_ch stalls the
// whole pipeline holds and req_ch drops ready; nothing is lost or repeated.
module point_to_pixel_index_projector #(
   parameter int MAX_COLS = ppip_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ppip_pkg::DEF_MAX_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   ppip_req_if.sink   req_ch,
   ppip_rsp_if.source rsp_ch,
   ppip_csr_if.sink   csr_ch
);

   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int QW    = (CW > RW) ? CW : RW;
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int LT    = QW + 7;
   localparam int SL    = QW + 5;   // linear index stage

   logic [ppip_pkg::PROJ_REGS-1:0][63:0] proj_ff;
   logic [10:0]                          cols_ff;
   logic [9:0]                           rows_ff;
   logic [CW-1:0]                        cols;
   logic [RW-1:0]                        rows;

   logic                 v_ff [LT];
   ppip_pkg::meta_type   m_ff [LT];
   logic                 en;
   logic                 busy;
   logic                 accept;

   logic signed [63:0] row0, row1, row2;
   logic [QW-1:0]      u_q, v_q;
   logic               u_ok, v_ok;

   logic [QW-1:0] bu_ff;
   logic [RW-1:0] bf_ff;
   logic          bok_ff;
   logic [AW-1:0] lin_ff;
   logic          lok_ff;
   logic [AW-1:0] out_lin_ff;
   logic          out_ok_ff;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic          mask_rd;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_ff <= '0;
         cols_ff <= ppip_pkg::COLS_RESET;
         rows_ff <= ppip_pkg::ROWS_RESET;
      end else if (csr_ch.valid) begin
         case (ppip_pkg::csr_index_type'(csr_ch.index))
            ppip_pkg::REG_IMAGE_COLS: cols_ff <= csr_ch.wdata[10:0];
            ppip_pkg::REG_IMAGE_ROWS: rows_ff <= csr_ch.wdata[9:0];
            default:                  proj_ff[csr_ch.index] <= csr_ch.wdata;
         endcase
      end
   end

   assign cols = (32'(cols_ff) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_ff);
   assign rows = (32'(rows_ff) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_ff);

   // flow control: everything advances unless a result waits
   assign en           = !(v_ff[LT-1] && !m_ff[LT-1].is_write && !rsp_ch.ready);
   assign req_ch.ready = en && !busy;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LT; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= accept;
         for (int k = 1; k < LT; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0].is_write     <= (req_ch.data.command == ppip_pkg::CMD_MASK_WRITE);
         m_ff[0].mask_address <= req_ch.data.mask_address;
         m_ff[0].mask_bit     <= req_ch.data.mask_bit;
         for (int k = 1; k < LT; k++) begin
            m_ff[k] <= m_ff[k-1];
         end
      end
   end

   ppip_mac u_mac (
      .clock   (clock),
      .en      (en),
      .point_x (req_ch.data.point_x),
      .point_y (req_ch.data.point_y),
      .point_z (req_ch.data.point_z),
      .proj    (proj_ff),
      .row0    (row0),
      .row1    (row1),
      .row2    (row2)
   );

   ppip_div #(.QW(QW)) u_div_u (
      .clock (clock), .en (en), .num (row0), .den (row2), .quot (u_q), .ok (u_ok)
   );

   ppip_div #(.QW(QW)) u_div_v (
      .clock (clock), .en (en), .num (row1), .den (row2), .quot (v_q), .ok (v_ok)
   );

   // bounds and row flip, then linear index
   always_ff @(posedge clock) begin
      if (en) begin
         bu_ff  <= u_q;
         bf_ff  <= RW'(rows - RW'(1) - RW'(v_q));
         bok_ff <= u_ok && v_ok && (32'(u_q) < 32'(cols)) && (32'(v_q) < 32'(rows));
         lin_ff <= AW'(bf_ff * cols) + AW'(bu_ff);
         lok_ff <= bok_ff;
         out_lin_ff <= lin_ff;
         out_ok_ff  <= lok_ff;
      end
   end

   assign mem_we   = v_ff[SL] && m_ff[SL].is_write
                     && (32'(m_ff[SL].mask_address) < 32'(DEPTH));
   assign mem_addr = m_ff[SL].is_write ? AW'(m_ff[SL].mask_address) : lin_ff;

   ppip_mask #(.DEPTH(DEPTH), .AW(AW)) u_mask (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .we    (mem_we),
      .wbit  (m_ff[SL].mask_bit),
      .addr  (mem_addr),
      .rd_ff (mask_rd),
      .busy  (busy)
   );

   assign rsp_ch.valid            = v_ff[LT-1] && !m_ff[LT-1].is_write;
   assign rsp_ch.data.hit         = out_ok_ff && mask_rd;
   assign rsp_ch.data.pixel_index = (out_ok_ff && mask_rd) ? 19'(out_lin_ff) : '0;

endmodule

FILE: rtl/ppip_mac.sv
// Three-stage matrix-vector product: 3x4 Q16.16 matrix times (x, y, z, 1).
module ppip_mac (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [31:0]      point_x,
   input  logic signed [31:0]      point_y,
   input  logic signed [31:0]      point_z,
   input  logic [ppip_pkg::PROJ_REGS-1:0][63:0] proj,
   output logic signed [63:0]      row0,
   output logic signed [63:0]      row1,
   output logic signed [63:0]      row2
);

   logic signed [63:0] prod_ff [3][4];
   logic signed [63:0] pair_ff [3][2];
   logic signed [63:0] sum_ff  [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= signed'(proj[2*r][31:0])    * point_x;
            prod_ff[r][1] <= signed'(proj[2*r][63:32])   * point_y;
            prod_ff[r][2] <= signed'(proj[2*r+1][31:0])  * point_z;
            prod_ff[r][3] <= 64'(signed'(proj[2*r+1][63:32])) <<< ppip_pkg::Q16_FRAC;
         end
         // arithmetic shift by two floors each Q32.32 term to Q34.30
         for (int r = 0; r < 3; r++) begin
            pair_ff[r][0] <= (prod_ff[r][0] >>> 2) + (prod_ff[r][1] >>> 2);
            pair_ff[r][1] <= (prod_ff[r][2] >>> 2) + (prod_ff[r][3] >>> 2);
         end
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= pair_ff[r][0] + pair_ff[r][1];
         end
      end
   end

   assign row0 = sum_ff[0];
   assign row1 = sum_ff[1];
   assign row2 = sum_ff[2];

endmodule

FILE: rtl/ppip_div.sv
// Pipelined restoring divider: q = floor(n / w + 1/2), one quotient bit per stage.
module ppip_div #(
   parameter int QW = 11
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic [QW-1:0]      quot,
   output logic               ok
);

   localparam int RWD = 64 + QW + 1;

   logic signed [65:0] nn;
   logic [63:0]        dd;
   logic [RWD-1:0]     lim;

   logic [RWD-1:0] rem_ff [QW+1];
   logic [63:0]    d_ff   [QW+1];
   logic [QW-1:0]  q_ff   [QW+1];
   logic           ok_ff  [QW+1];

   // floor(n/w + 1/2) = floor((2n + w) / 2w)
   assign nn  = (66'(num) <<< 1) + 66'(den);
   assign dd  = {den[62:0], 1'b0};
   assign lim = RWD'(dd) << QW;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RWD'(nn[64:0]);
         d_ff[0]   <= dd;
         q_ff[0]   <= '0;
         ok_ff[0]  <= (den > 64'sd0) && !nn[65] && (RWD'(nn[64:0]) < lim);
         for (int k = 0; k < QW; k++) begin
            d_ff[k+1]  <= d_ff[k];
            ok_ff[k+1] <= ok_ff[k];
            if (rem_ff[k] >= (RWD'(d_ff[k]) << (QW-1-k))) begin
               rem_ff[k+1] <= rem_ff[k] - (RWD'(d_ff[k]) << (QW-1-k));
               q_ff[k+1]   <= q_ff[k] | (QW'(1) << (QW-1-k));
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               q_ff[k+1]   <= q_ff[k];
            end
         end
      end
   end

   assign quot = q_ff[QW];
   assign ok   = ok_ff[QW];

endmodule

FILE: rtl/ppip_mask.sv
// Pixel mask memory, one bit per pixel, filled with ones by a pass after reset.
module ppip_mask #(
   parameter int DEPTH = 524288,
   parameter int AW    = 19
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          we,
   input  logic          wbit,
   input  logic [AW-1:0] addr,
   output logic          rd_ff,
   output logic          busy
);

   logic          mem [DEPTH];
   logic [AW-1:0] clr_ff;
   logic          busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == AW'(DEPTH-1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= 1'b1;
      end else if (en && we) begin
         mem[addr] <= wbit;
      end
      if (en) begin
         rd_ff <= mem[addr];
      end
   end

   assign busy = busy_ff;

endmodule

FILE: rtl/ppip_checker.sv
// Port-level checks of the projector, bound to the top level.
module ppip_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [18:0] rsp_pixel_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_pixel_index == 19'd0)
      else $error("miss with non-zero index");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   a_fill_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during mask fill");

endmodule

bind point_to_pixel_index_projector ppip_port_checks u_ppip_port_checks (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_hit         (rsp_ch.data.hit),
   .rsp_pixel_index (rsp_ch.data.pixel_index)
);
